FILE: design/pending_reply_retry_table_macros.svh
// ----------------------------------------------------------------------------
// pending_reply_retry_table_macros
// Assertion macros shared by the design files.
// ----------------------------------------------------------------------------
`ifndef PENDING_REPLY_RETRY_TABLE_MACROS_SVH
`define PENDING_REPLY_RETRY_TABLE_MACROS_SVH
// Implication checked at every clock edge outside reset
`define PRT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset
`define PRT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: design/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types and constants for the pending reply retry table.
// ----------------------------------------------------------------------------
package prt_pkg;
  localparam int SLOTS_DEF    = 16;
  localparam int KEY_BITS_DEF = 64;
  localparam int KEY_W        = 64;
  localparam int TIME_W       = 32;

  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_MATCH    = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;
  localparam logic [1:0] CMD_CLEAR    = 2'd3;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_RESEND  = 1'b1;

  // request as passed from front to back
  typedef struct packed {
    logic [1:0]        cmd;
    logic [KEY_W-1:0]  key;
    logic [7:0]        fmt;
    logic [7:0]        retries;
    logic              watchdog;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  // one result item
  typedef struct packed {
    logic             is_resend;
    logic [KEY_W-1:0] resend_key;
    logic [7:0]       resend_fmt;
    logic             accepted;
    logic [4:0]       watchdog_failures;
    logic             last;
  } res_t;
endpackage

FILE: design/prt_ram.sv
// ----------------------------------------------------------------------------
// prt_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module prt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/prt_front.sv
// ----------------------------------------------------------------------------
// prt_front
// Two-entry request queue that decouples the input port from the slot engine.
// ----------------------------------------------------------------------------
module prt_front #(
  parameter int KEY_BITS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  prt_pkg::req_t   in_req,
  output logic            req_valid,
  output prt_pkg::req_t   req,
  input  logic            req_take
);
  import prt_pkg::*;
  `include "pending_reply_retry_table_macros.svh"

  req_t        q [2];
  logic        wptr, rptr;
  logic [1:0]  count;
  logic        do_push, do_pop;
  req_t        norm;

  // mask key down to the used bits on the way in
  always_comb begin
    norm = in_req;
    norm.key = in_req.key & ({KEY_W{1'b1}} >> (KEY_W - KEY_BITS));
  end

  assign full      = (count == 2'd2);
  assign req_valid = (count != 2'd0);
  assign req       = q[rptr];
  assign do_push   = push && !full;
  assign do_pop    = req_take && req_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wptr] <= norm;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop) rptr <= ~rptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  `PRT_ASSERT_IMP(a_no_over, clk, rst, 1'b1, count <= 2'd2, "queue count overflow")
  `PRT_ASSERT_NXT(a_fill, clk, rst, do_push && !do_pop, count == $past(count) + 2'd1,
    "queue count did not grow on push")
  `PRT_ASSERT_IMP(a_take, clk, rst, req_take, req_valid, "take from empty queue")
endmodule

FILE: design/prt_back.sv
// ----------------------------------------------------------------------------
// prt_back
// Slot engine: scans the table slot by slot, reading then evaluating each, and
// emits results into a two-entry output queue.
// ----------------------------------------------------------------------------
module prt_back #(
  parameter int SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  prt_pkg::req_t               req,
  output logic                        req_take,
  input  logic [prt_pkg::TIME_W-1:0]  due_after,
  input  logic                        resend_enable,
  output logic                        empty,
  input  logic                        pop,
  output prt_pkg::res_t               res
);
  import prt_pkg::*;
  `include "pending_reply_retry_table_macros.svh"

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SW = KEY_W + TIME_W + 8 + 1 + 8;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]   state;
  logic [CW-1:0] idx;
  logic [SLOTS-1:0] valid;
  req_t         cur;
  logic [4:0]   fails;
  logic         acc;

  // slot memory: key, sent time, retries, watchdog, format
  logic          we;
  logic [IW-1:0] waddr;
  logic [SW-1:0] wdata, rdata;
  logic [KEY_W-1:0]  s_key;
  logic [TIME_W-1:0] s_time;
  logic [7:0]        s_ret;
  logic              s_wd;
  logic [7:0]        s_fmt;
  assign {s_key, s_time, s_ret, s_wd, s_fmt} = rdata;

  prt_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(idx[IW-1:0]), .rdata(rdata)
  );

  // output queue
  res_t       oq [2];
  logic       owp, orp;
  logic [1:0] ocnt;
  logic       opush;
  res_t       ores;
  logic       ofree;

  assign empty = (ocnt == 2'd0);
  assign res   = oq[orp];
  assign ofree = (ocnt == 2'd0) || (ocnt == 2'd1) || pop;

  logic [IW-1:0] slot;
  logic          sv, due, last_slot;
  logic [TIME_W-1:0] elapsed;
  assign slot      = idx[IW-1:0];
  assign sv        = valid[slot];
  assign elapsed   = cur.now_ms - s_time;
  assign due       = sv && (elapsed >= due_after);
  assign last_slot = (idx == CW'(SLOTS - 1));

  logic [1:0]  state_next;
  logic [CW-1:0] idx_next;
  logic [SLOTS-1:0] valid_next;
  logic [4:0]  fails_next;
  logic        acc_next;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    valid_next = valid;
    fails_next = fails;
    acc_next   = acc;
    req_take   = 1'b0;
    we         = 1'b0;
    waddr      = slot;
    wdata      = {cur.key, cur.now_ms, cur.retries, cur.watchdog, cur.fmt};
    opush      = 1'b0;
    ores       = '0;
    ores.last  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        idx_next   = '0;
        fails_next = '0;
        acc_next   = 1'b0;
        if (req_valid) begin
          req_take = 1'b1;
          if (req.cmd == CMD_CLEAR) begin
            valid_next = '0;
            state_next = ST_DONE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: state_next = ST_EVAL;
      ST_EVAL: begin
        state_next = ST_READ;
        idx_next   = idx + CW'(1);
        case (cur.cmd)
          CMD_REGISTER: begin
            if (!sv) begin
              acc_next = 1'b1;
              if (cur.key != '0) begin
                we = 1'b1;
                valid_next[slot] = 1'b1;
              end
              state_next = ST_DONE;
            end
          end
          CMD_MATCH: begin
            if (cur.key == '0 || (sv && s_key == cur.key)) begin
              valid_next[slot] = 1'b0;
              if (cur.key == '0) valid_next = valid;
              state_next = ST_DONE;
            end
          end
          default: begin
            if (due) begin
              if (s_ret == 8'd0) begin
                valid_next[slot] = 1'b0;
                if (s_wd && fails != 5'd31) fails_next = fails + 5'd1;
              end else if (resend_enable && !ofree) begin
                // wait for room in the output queue
                state_next = ST_EVAL;
                idx_next   = idx;
              end else begin
                we    = 1'b1;
                wdata = {s_key, cur.now_ms, s_ret - 8'd1, s_wd, s_fmt};
                if (resend_enable) begin
                  opush = 1'b1;
                  ores.is_resend  = 1'b1;
                  ores.resend_key = s_key;
                  ores.resend_fmt = s_fmt;
                  ores.last       = 1'b0;
                end
              end
            end
          end
        endcase
        if (last_slot && state_next == ST_READ) state_next = ST_DONE;
      end
      default: begin
        if (ofree) begin
          opush = 1'b1;
          ores.accepted = acc;
          ores.watchdog_failures = (cur.cmd == CMD_TICK) ? fails : 5'd0;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_take) cur <= req;
    if (opush) oq[owp] <= ores;
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      valid <= '0;
      fails <= '0;
      acc   <= 1'b0;
      owp   <= 1'b0;
      orp   <= 1'b0;
      ocnt  <= 2'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      valid <= valid_next;
      fails <= fails_next;
      acc   <= acc_next;
      if (opush) owp <= ~owp;
      if (pop && !empty) orp <= ~orp;
      ocnt <= ocnt + {1'b0, opush} - {1'b0, pop && !empty};
    end
  end

  `PRT_ASSERT_IMP(a_oq_room, clk, rst, opush, ofree, "result queue overrun")
  `PRT_ASSERT_IMP(a_take_idle, clk, rst, req_take, state == ST_IDLE, "take while busy")
  `PRT_ASSERT_NXT(a_done_idle, clk, rst, state == ST_DONE && ofree, state == ST_IDLE,
    "command result not followed by idle")
endmodule

FILE: design/pending_reply_retry_table.sv
// ----------------------------------------------------------------------------
// pending_reply_retry_table
// Table of outstanding requests with reply matching, timeout retry and expiry.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue; the slot engine behind it walks the table
// slot by slot, reading the memory and then evaluating each slot. Register stops
// at the first free slot and match at the first hit; a tick always walks every
// slot and may stall on the result queue; clear skips the walk entirely.
// Results leave through a two-entry queue, so one waiting result never blocks
// the input side.
module pending_reply_retry_table #(
  parameter int SLOTS    = prt_pkg::SLOTS_DEF,
  parameter int KEY_BITS = prt_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [63:0] key,
  input  logic [7:0]  fmt,
  input  logic [7:0]  retries,
  input  logic        watchdog,
  input  logic [31:0] now_ms,
  output logic        empty,
  input  logic        pop,
  output logic        is_resend,
  output logic [63:0] resend_key,
  output logic [7:0]  resend_fmt,
  output logic        accepted,
  output logic [4:0]  watchdog_failures,
  output logic        last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import prt_pkg::*;

  req_t  in_req, req;
  res_t  res;
  logic  req_valid, req_take;
  logic [31:0] due_after;
  logic        resend_enable;

  assign in_req = '{cmd: cmd, key: key, fmt: fmt, retries: retries,
                    watchdog: watchdog, now_ms: now_ms};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      due_after     <= 32'd1000;
      resend_enable <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TIMEOUT) due_after <= cfg_data;
      else resend_enable <= cfg_data[0];
    end
  end

  prt_front #(.KEY_BITS(KEY_BITS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_req(in_req),
    .req_valid(req_valid), .req(req), .req_take(req_take)
  );

  prt_back #(.SLOTS(SLOTS)) u_back (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req(req), .req_take(req_take),
    .due_after(due_after), .resend_enable(resend_enable),
    .empty(empty), .pop(pop), .res(res)
  );

  assign is_resend         = res.is_resend;
  assign resend_key        = res.resend_key;
  assign resend_fmt        = res.resend_fmt;
  assign accepted          = res.accepted;
  assign watchdog_failures = res.watchdog_failures;
  assign last              = res.last;
endmodule
